// File: design/bcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Binomial checkpoint scheduler package
// Shared widths, status codes, payload structs, the sequencer state type and
// the control bundles between the sequencer and the multiply-divide unit.
// ----------------------------------------------------------------------------
package bcs_pkg;

	// Field widths of the request and result.
	localparam int LAYER_W = 10;
	localparam int SAVES_W = 7;

	// The binomial range stays below 2^(LAYER_W+SAVES_W).
	localparam int RANGE_W = LAYER_W + SAVES_W;
	// Multiplier and divisor operands (repetitions plus free saves).
	localparam int OPND_W  = LAYER_W + 1;
	// Every product that the schedule forms stays below 2^PROD_W.
	localparam int PROD_W  = LAYER_W + OPND_W;

	// Defaults for the top-level parameters and the register reset.
	localparam int DEF_MAX_LAYERS = 1024;
	localparam int DEF_MAX_SAVES  = 64;
	localparam logic [SAVES_W-1:0] MAX_SAVES_RST = SAVES_W'(8);

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_SAVES  = 2'd1;
	localparam logic [1:0] STATUS_NOT_AHEAD = 2'd2;

	// Request payload.
	typedef struct packed {
		logic [LAYER_W-1:0] target_layer;
		logic [LAYER_W-1:0] last_checkpoint_layer;
		logic [SAVES_W-1:0] checkpoints_held;
	} sched_req_t;

	// Result payload.
	typedef struct packed {
		logic [LAYER_W-1:0] next_layer;
		logic [1:0]         status;
	} sched_rsp_t;

	// Operation handed to the multiply-divide unit: (mul_a * mul_b) / divisor.
	typedef struct packed {
		logic               start;
		logic [RANGE_W-1:0] mul_a;
		logic [OPND_W-1:0]  mul_b;
		logic [OPND_W-1:0]  divisor;
	} md_req_t;

	// Completion from the multiply-divide unit.
	typedef struct packed {
		logic               done;
		logic [RANGE_W-1:0] quot;
	} md_rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOOP,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_B4,
		ST_B5,
		ST_SEL,
		ST_CLAMP,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: design/bcs_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiply-divide unit
// Forms a product, then divides it by an unsigned divisor with a
// restoring radix-2 divider, one quotient bit per cycle. The quotient is
// truncated toward zero.
// ----------------------------------------------------------------------------
module bcs_muldiv import bcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam int CNT_W = $clog2(PROD_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [PROD_W-1:0]         dvd_q;
	logic [OPND_W-1:0]         rem_q;
	logic [OPND_W-1:0]         dsr_q;
	logic [RANGE_W+OPND_W-1:0] full_prod;
	logic [OPND_W:0]           trial;
	logic [OPND_W:0]           trial_diff;
	logic                      fits;

	// The schedule's products stay below 2^PROD_W, so the upper bits are dropped.
	assign full_prod  = req.mul_a * req.mul_b;
	assign trial      = {rem_q, dvd_q[PROD_W-1]};
	assign fits       = trial >= {1'b0, dsr_q};
	assign trial_diff = trial - {1'b0, dsr_q};

	// Control: a load on start, then PROD_W divide steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Datapath: quotient bits shift in where dividend bits shift out.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= full_prod[PROD_W-1:0];
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], fits};
			rem_q <= fits ? trial_diff[OPND_W-1:0] : trial[OPND_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q[RANGE_W-1:0];

endmodule
`default_nettype wire

// File: design/binomial_checkpoint_scheduler_core.sv
// The request is accepted and its status checked; then each binomial step of the range
// search and each of the five terms runs in the shared multiply-divide unit (a
// multiply, 21 divide steps, a hand-off), or skips the unit for a term that needs
// no division; then search exit, select, clamp and output follow.
// One request makes up to reps+5 passes through the unit, reps up to the layer distance.
// A status-only result skips the search and the terms. One request is worked on at a time.
// Reset is asynchronous: the sequencer idles, max_saves returns to 8.
`default_nettype none
// ----------------------------------------------------------------------------
// Binomial checkpoint scheduler core
// Picks the layer at which the next checkpoint is stored, following the
// binomial schedule, with one shared multiply-divide unit under a sequencer.
// ----------------------------------------------------------------------------
module binomial_checkpoint_scheduler_core import bcs_pkg::*; #(
	parameter int MAX_LAYERS = DEF_MAX_LAYERS,
	parameter int MAX_SAVES  = DEF_MAX_SAVES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [SAVES_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  sched_req_t         in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sched_rsp_t         out_data
);

	localparam int NW = RANGE_W + 2;
	localparam logic [31:0] LAYER_TOP = 32'(MAX_LAYERS - 1);
	localparam logic [8:0]  SAVES_TOP = 9'(MAX_SAVES);

	state_t state_q, state_d;
	logic   wait_q, wait_d;

	logic [SAVES_W-1:0] max_saves_q;
	logic [LAYER_W-1:0] target_q;
	logic [LAYER_W-1:0] last_q;
	logic [SAVES_W-1:0] held_q;
	logic [LAYER_W-1:0] dist_q;
	logic [SAVES_W-1:0] free_q;
	logic [RANGE_W-1:0] range_q;
	logic [LAYER_W-1:0] reps_q;
	logic [RANGE_W-1:0] b1_q, b2_q, b3_q, b4_q, b5_q;
	logic signed [NW-1:0] cand_q;
	logic [LAYER_W-1:0] res_next_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;
	sched_rsp_t         out_data_q;

	md_req_t md_req;
	md_rsp_t md_rsp;
	logic    md_start;

	logic [OPND_W-1:0]  reps_x, free_x;
	logic               op_skip;
	logic [RANGE_W-1:0] op_fixed;
	state_t             op_next;
	logic               ld_en;
	logic [RANGE_W-1:0] ld_val;
	logic               out_load;

	logic [RANGE_W:0]     sum13;
	logic [RANGE_W-1:0]   range_m5;
	logic                 near_end;
	logic signed [NW-1:0] last_s, target_s, cand_d;
	logic signed [NW-1:0] lifted;
	logic [LAYER_W-1:0]   clamped;

	assign reps_x = OPND_W'(reps_q);
	assign free_x = OPND_W'(free_q);

	bcs_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// Layer selection from the five terms.
	assign last_s   = signed'(NW'(last_q));
	assign target_s = signed'(NW'(target_q));
	assign sum13    = {1'b0, b1_q} + {1'b0, b3_q};
	assign range_m5 = range_q - b5_q;
	assign near_end = (range_q >= b5_q) && (RANGE_W'(dist_q) >= range_m5);

	always_comb begin
		priority if ((RANGE_W + 1)'(dist_q) <= sum13) begin
			cand_d = last_s + signed'(NW'(b4_q));
		end else if (near_end) begin
			cand_d = last_s + signed'(NW'(b1_q));
		end else begin
			cand_d = target_s - signed'(NW'(b2_q)) - signed'(NW'(b3_q));
		end
	end

	// Force forward progress, then saturate to the last layer.
	assign lifted = (cand_q <= last_s) ? (last_s + signed'(NW'(1))) : cand_q;

	always_comb begin
		if (32'(unsigned'(lifted)) > LAYER_TOP) begin
			clamped = LAYER_TOP[LAYER_W-1:0];
		end else begin
			clamped = lifted[LAYER_W-1:0];
		end
	end

	// Operands of each term, and the terms that need no division.
	always_comb begin
		md_req.start   = md_start;
		md_req.mul_a   = range_q;
		md_req.mul_b   = reps_x;
		md_req.divisor = free_x + reps_x;
		op_skip        = 1'b0;
		op_fixed       = '0;
		op_next        = ST_SEL;
		unique case (state_q)
			ST_LOOP: begin
				md_req.mul_a   = range_q;
				md_req.mul_b   = reps_x + free_x + OPND_W'(1);
				md_req.divisor = reps_x + OPND_W'(1);
				op_next        = ST_B1;
			end
			ST_B1: begin
				md_req.mul_a   = range_q;
				md_req.mul_b   = reps_x;
				md_req.divisor = free_x + reps_x;
				op_next        = ST_B2;
			end
			ST_B2: begin
				md_req.mul_a   = b1_q;
				md_req.mul_b   = free_x;
				md_req.divisor = free_x + reps_x - OPND_W'(1);
				op_skip        = (free_q == SAVES_W'(1));
				op_fixed       = RANGE_W'(1);
				op_next        = ST_B3;
			end
			ST_B3: begin
				md_req.mul_a   = b2_q;
				md_req.mul_b   = free_x - OPND_W'(1);
				md_req.divisor = free_x + reps_x - OPND_W'(2);
				op_skip        = (free_q <= SAVES_W'(2));
				op_fixed       = (free_q == SAVES_W'(2)) ? RANGE_W'(1) : '0;
				op_next        = ST_B4;
			end
			ST_B4: begin
				md_req.mul_a   = b2_q;
				md_req.mul_b   = reps_x - OPND_W'(1);
				md_req.divisor = free_x;
				op_next        = ST_B5;
			end
			ST_B5: begin
				md_req.mul_a   = b3_q;
				md_req.mul_b   = free_x - OPND_W'(2);
				md_req.divisor = reps_x;
				op_skip        = (free_q <= SAVES_W'(3));
				op_fixed       = (free_q == SAVES_W'(3)) ? RANGE_W'(1) : '0;
				op_next        = ST_SEL;
			end
			default: begin
				op_next = ST_SEL;
			end
		endcase
	end

	// Next state, unit start and term loads.
	always_comb begin
		state_d      = state_q;
		wait_d       = wait_q;
		md_start     = 1'b0;
		ld_en        = 1'b0;
		ld_val       = md_rsp.quot;
		out_load     = 1'b0;
		in_ready     = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (target_q <= last_q || held_q >= max_saves_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (!wait_q) begin
					if (range_q > RANGE_W'(dist_q)) begin
						state_d = op_next;
					end else begin
						md_start = 1'b1;
						wait_d   = 1'b1;
					end
				end else if (md_rsp.done) begin
					ld_en  = 1'b1;
					wait_d = 1'b0;
				end
			end
			ST_B1, ST_B2, ST_B3, ST_B4, ST_B5: begin
				if (!wait_q) begin
					if (op_skip) begin
						ld_en   = 1'b1;
						ld_val  = op_fixed;
						state_d = op_next;
					end else begin
						md_start = 1'b1;
						wait_d   = 1'b1;
					end
				end else if (md_rsp.done) begin
					ld_en   = 1'b1;
					wait_d  = 1'b0;
					state_d = op_next;
				end
			end
			ST_SEL: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers and the max_saves register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			max_saves_q <= MAX_SAVES_RST;
		end else begin
			state_q <= state_d;
			wait_q  <= wait_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				if (9'(cfg_wr_data) > SAVES_TOP) begin
					max_saves_q <= SAVES_TOP[SAVES_W-1:0];
				end else begin
					max_saves_q <= cfg_wr_data;
				end
			end
		end
	end

	// Working registers of the schedule.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			target_q <= in_data.target_layer;
			last_q   <= in_data.last_checkpoint_layer;
			held_q   <= in_data.checkpoints_held;
		end
		if (state_q == ST_CHECK) begin
			dist_q       <= target_q - last_q;
			free_q       <= max_saves_q - held_q;
			range_q      <= RANGE_W'(1);
			reps_q       <= '0;
			res_next_q   <= '0;
			res_status_q <= (target_q <= last_q) ? STATUS_NOT_AHEAD : STATUS_NO_SAVES;
		end
		if (state_q == ST_LOOP && md_start) begin
			reps_q <= reps_q + LAYER_W'(1);
		end
		if (ld_en) begin
			unique case (state_q)
				ST_LOOP: range_q <= ld_val;
				ST_B1:   b1_q    <= ld_val;
				ST_B2:   b2_q    <= ld_val;
				ST_B3:   b3_q    <= ld_val;
				ST_B4:   b4_q    <= ld_val;
				ST_B5:   b5_q    <= ld_val;
				default: b5_q    <= b5_q;
			endcase
		end
		if (state_q == ST_SEL) begin
			cand_q <= cand_d;
		end
		if (state_q == ST_CLAMP) begin
			res_next_q   <= clamped;
			res_status_q <= STATUS_OK;
		end
		if (out_load) begin
			out_data_q.next_layer <= res_next_q;
			out_data_q.status     <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The unit only completes an operation that the sequencer waits for.
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> wait_q)
		else $error("multiply-divide completion without a pending operation");

	// The repetition count never passes the layer distance.
	a_reps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> (reps_q <= dist_q))
		else $error("repetition count beyond layer distance");

	// A fault status carries layer zero.
	a_fault_layer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status != STATUS_OK) |-> (out_data_q.next_layer == '0))
		else $error("nonzero layer with a fault status");

	// Only defined status codes leave the block.
	a_status_defined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.status == STATUS_OK
			|| out_data_q.status == STATUS_NO_SAVES
			|| out_data_q.status == STATUS_NOT_AHEAD))
		else $error("undefined status code");

endmodule
`default_nettype wire
